// File: design/ksc_pkg.sv
// Package for the keypad scanner: key state codes, register map, reset values,
// shared structs and the next-state function of a plain (non-repeating) key.
// No dependencies.
`default_nettype none

package ksc_pkg;

  // key state codes
  localparam logic [1:0] KS_IDLE    = 2'd0;
  localparam logic [1:0] KS_EVENT   = 2'd1;
  localparam logic [1:0] KS_PRESSED = 2'd2;
  localparam logic [1:0] KS_SPARE   = 2'd3;  // never produced, reads as event

  // register map, word index = paddr[3:2]
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;
  localparam logic [1:0] REG_SAMPLE_PERIOD  = 2'd0;
  localparam logic [1:0] REG_LONG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_REPEAT_PERIOD  = 2'd2;

  localparam logic [7:0]  SAMPLE_PERIOD_RST  = 8'd20;
  localparam logic [15:0] LONG_THRESHOLD_RST = 16'd75;
  localparam logic [7:0]  REPEAT_PERIOD_RST  = 8'd20;

  localparam logic [15:0] HOLD_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  sample_period;
    logic [15:0] long_threshold;
    logic [7:0]  repeat_period;
  } cfg_t;

  // per-request control for an auto-repeat key
  typedef struct packed {
    logic scan;
    logic level;
    logic clr;
    logic clr_long;
  } rkey_ctl_t;

  typedef struct packed {
    logic evt;
    logic lng;
  } rkey_sts_t;

  function automatic logic is_event(input logic [1:0] ks);
    is_event = (ks == KS_EVENT) || (ks == KS_SPARE);
  endfunction

  function automatic logic [1:0] simple_next(input logic [1:0] ks, input logic clr,
                                             input logic scan, input logic level);
    logic [1:0] k;
    k = clr ? KS_IDLE : ks;
    simple_next = k;
    if (scan) begin
      case (k)
        KS_IDLE:    simple_next = level ? KS_IDLE : KS_PRESSED;
        KS_PRESSED: simple_next = level ? KS_EVENT : KS_PRESSED;
        default:    simple_next = k;
      endcase
    end
  endfunction

endpackage

`default_nettype wire

// File: design/ksc_if.sv
// Valid/ready channel interfaces for the keypad scanner: tick request in,
// key status out. No dependencies.
`default_nettype none

interface ksc_in_if;
  logic valid;
  logic ready;
  logic set_level;
  logic up_level;
  logic down_level;
  logic return_level;
  logic clear_set;
  logic clear_up;
  logic clear_down;
  logic clear_return;
  logic clear_up_long;
  logic clear_down_long;

  modport source (output valid, set_level, up_level, down_level, return_level,
                  clear_set, clear_up, clear_down, clear_return, clear_up_long,
                  clear_down_long, input ready);
  modport sink (input valid, set_level, up_level, down_level, return_level,
                clear_set, clear_up, clear_down, clear_return, clear_up_long,
                clear_down_long, output ready);
endinterface

interface ksc_out_if;
  logic valid;
  logic ready;
  logic set_event;
  logic up_event;
  logic down_event;
  logic return_event;
  logic up_long;
  logic down_long;

  modport source (output valid, set_event, up_event, down_event, return_event,
                  up_long, down_long, input ready);
  modport sink (input valid, set_event, up_event, down_event, return_event,
                up_long, down_long, output ready);
endinterface

`default_nettype wire

// File: design/ksc_cfg.sv
// APB-style configuration registers of the keypad scanner.
// Depends on ksc_pkg.
`default_nettype none

module ksc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [ksc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [ksc_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic      [ksc_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output ksc_pkg::cfg_t                     cfg
);

  ksc_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;
  logic [1:0]    idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        ksc_pkg::REG_SAMPLE_PERIOD:  cfg_nxt.sample_period  = cfg_pwdata[7:0];
        ksc_pkg::REG_LONG_THRESHOLD: cfg_nxt.long_threshold = cfg_pwdata[15:0];
        ksc_pkg::REG_REPEAT_PERIOD:  cfg_nxt.repeat_period  = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ksc_pkg::REG_SAMPLE_PERIOD:  cfg_prdata = {24'd0, cfg_r.sample_period};
      ksc_pkg::REG_LONG_THRESHOLD: cfg_prdata = {16'd0, cfg_r.long_threshold};
      ksc_pkg::REG_REPEAT_PERIOD:  cfg_prdata = {24'd0, cfg_r.repeat_period};
      default:                     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_period  <= ksc_pkg::SAMPLE_PERIOD_RST;
      cfg_r.long_threshold <= ksc_pkg::LONG_THRESHOLD_RST;
      cfg_r.repeat_period  <= ksc_pkg::REPEAT_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: design/ksc_rkey.sv
// One auto-repeat key (Up or Down): key state, saturating hold count,
// repeat phase and long flag. Depends on ksc_pkg.
`default_nettype none

module ksc_rkey (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire ksc_pkg::rkey_ctl_t ctl,
  input  wire ksc_pkg::cfg_t      cfg,
  output ksc_pkg::rkey_sts_t      sts_nxt
);

  logic [1:0]  ks_r, ks_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [7:0]  phase_r, phase_nxt;
  logic        long_r, long_nxt;

  logic [1:0]  ks_c;
  logic [15:0] hold_inc;
  logic [7:0]  phase_inc, rp;
  logic        past_thr;

  always_comb begin
    ks_c      = ctl.clr ? ksc_pkg::KS_IDLE : ks_r;
    ks_nxt    = ks_c;
    hold_nxt  = hold_r;
    phase_nxt = phase_r;
    long_nxt  = ctl.clr_long ? 1'b0 : long_r;
    rp        = (cfg.repeat_period == 8'd0) ? 8'd1 : cfg.repeat_period;
    hold_inc  = (hold_r == ksc_pkg::HOLD_MAX) ? hold_r : hold_r + 16'd1;
    phase_inc = phase_r + 8'd1;
    if (phase_inc >= rp) begin
      phase_inc = 8'd0;
    end
    past_thr  = hold_inc >= cfg.long_threshold;
    if (ctl.scan) begin
      case (ks_c)
        ksc_pkg::KS_IDLE: begin
          if (!ctl.level) begin
            ks_nxt = ksc_pkg::KS_PRESSED;
          end
        end
        ksc_pkg::KS_PRESSED: begin
          if (ctl.level) begin
            // release: short press gives an event, long press just ends
            ks_nxt    = past_thr ? ksc_pkg::KS_IDLE : ksc_pkg::KS_EVENT;
            long_nxt  = past_thr ? 1'b0 : long_nxt;
            hold_nxt  = '0;
            phase_nxt = '0;
          end else begin
            hold_nxt  = hold_inc;
            phase_nxt = phase_inc;
            if (past_thr && phase_inc == 8'd0) begin
              long_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r    <= ksc_pkg::KS_IDLE;
      hold_r  <= '0;
      phase_r <= '0;
      long_r  <= 1'b0;
    end else if (step) begin
      ks_r    <= ks_nxt;
      hold_r  <= hold_nxt;
      phase_r <= phase_nxt;
      long_r  <= long_nxt;
    end
  end

  assign sts_nxt.evt = ksc_pkg::is_event(ks_nxt);
  assign sts_nxt.lng = long_nxt;

endmodule

`default_nettype wire

// File: design/key_scanner_long_press_repeat.sv
// Keypad scanner with long-press auto-repeat, top level.
// Path: an accepted request passes the input register, then the result register;
// throughput: one request per cycle while the result side does not stall.
// Reset (synchronous, rst_n low): all keys idle, counters and flags zero,
// registers back to their defaults; no request is taken while in reset.
// Depends on ksc_pkg, ksc_if, ksc_cfg, ksc_rkey.
`default_nettype none

module key_scanner_long_press_repeat (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  ksc_in_if.sink                          in_if,
  ksc_out_if.source                       out_if,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [ksc_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [ksc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [ksc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  ksc_pkg::cfg_t cfg;

  ksc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // input register
  logic       s1_v_r;
  logic [3:0] s1_lvl_r;   // set, up, down, return
  logic [3:0] s1_clr_r;
  logic [1:0] s1_clrl_r;  // up, down

  // result register
  logic       out_v_r;
  logic [3:0] out_evt_r;
  logic [1:0] out_lng_r;

  logic accept, adv, step;

  assign adv         = !out_v_r || out_if.ready;
  assign in_if.ready = rst_n && (!s1_v_r || adv);
  assign accept      = in_if.valid && in_if.ready;
  assign step        = s1_v_r && adv;

  // tick divider
  logic [7:0] div_r, div_nxt, div_inc;
  logic       scan;

  always_comb begin
    div_inc = div_r + 8'd1;
    scan    = div_inc >= cfg.sample_period;
    div_nxt = scan ? 8'd0 : div_inc;
  end

  // plain keys: set and return
  logic [1:0] set_ks_r, set_ks_nxt, ret_ks_r, ret_ks_nxt;

  assign set_ks_nxt = ksc_pkg::simple_next(set_ks_r, s1_clr_r[0], scan, s1_lvl_r[0]);
  assign ret_ks_nxt = ksc_pkg::simple_next(ret_ks_r, s1_clr_r[3], scan, s1_lvl_r[3]);

  // auto-repeat keys: up and down
  ksc_pkg::rkey_ctl_t up_ctl, dn_ctl;
  ksc_pkg::rkey_sts_t up_sts, dn_sts;

  assign up_ctl = '{scan: scan, level: s1_lvl_r[1], clr: s1_clr_r[1], clr_long: s1_clrl_r[0]};
  assign dn_ctl = '{scan: scan, level: s1_lvl_r[2], clr: s1_clr_r[2], clr_long: s1_clrl_r[1]};

  ksc_rkey u_up (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .ctl     (up_ctl),
    .cfg     (cfg),
    .sts_nxt (up_sts)
  );

  ksc_rkey u_dn (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .ctl     (dn_ctl),
    .cfg     (cfg),
    .sts_nxt (dn_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      div_r    <= '0;
      set_ks_r <= ksc_pkg::KS_IDLE;
      ret_ks_r <= ksc_pkg::KS_IDLE;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
      if (step) begin
        div_r    <= div_nxt;
        set_ks_r <= set_ks_nxt;
        ret_ks_r <= ret_ks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lvl_r  <= {in_if.return_level, in_if.down_level, in_if.up_level, in_if.set_level};
      s1_clr_r  <= {in_if.clear_return, in_if.clear_down, in_if.clear_up, in_if.clear_set};
      s1_clrl_r <= {in_if.clear_down_long, in_if.clear_up_long};
    end
    if (step) begin
      out_evt_r <= {ksc_pkg::is_event(ret_ks_nxt), dn_sts.evt, up_sts.evt,
                    ksc_pkg::is_event(set_ks_nxt)};
      out_lng_r <= {dn_sts.lng, up_sts.lng};
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.set_event    = out_evt_r[0];
  assign out_if.up_event     = out_evt_r[1];
  assign out_if.down_event   = out_evt_r[2];
  assign out_if.return_event = out_evt_r[3];
  assign out_if.up_long      = out_lng_r[0];
  assign out_if.down_long    = out_lng_r[1];

endmodule

`default_nettype wire

// File: design/ksc_chk.sv
// Port-level checker for the keypad scanner, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none

module ksc_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic cfg_pready
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // first result after reset
  a_rst_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // request side only backs up when a result is waiting
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("request stalled with empty result register");

  // a fresh result needs a request that passed the input register, then the result register
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without request");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind key_scanner_long_press_repeat ksc_chk u_ksc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .cfg_pready (cfg_pready)
);

`default_nettype wire
